@@ src/dll_pkg.sv @@
`timescale 1ns / 1ps

package dll_pkg;

  localparam int POOL_SIZE_DEF = 256;

  // fixed field widths of the stream ports
  localparam int ID_W       = 8;
  localparam int ACT_W      = 3;
  localparam int COUNT_W    = 9;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_QUERY      = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic accept;
    logic step_a;
    logic step_b;
    logic load_out;
  } ctrl_cmd_t;

endpackage

@@ src/doubly_linked_list_manager_top.sv @@
// The result is registered on the master side at the end of the second write slot, once the output is free.
// A request is handled in steps (accept with link read, then two write
// slots, since each link RAM has a single write port); the next request is accepted only after them.
// A result still waiting on the master side when the second write slot ends holds off the next request.
// Reset (async, active low): head and tail null, count zero; link RAMs are not cleared.
`timescale 1ns / 1ps

module doubly_linked_list_manager_top #(
  parameter int POOL_SIZE = dll_pkg::POOL_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] element_id
  input  logic [dll_pkg::ACT_W-1:0]        s_axis_tuser_i,  // [2:0] action
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] popped_id, [16:8] item_count, [17] is_empty, [23:18] zero
  output logic [dll_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tuser_o   // [0] popped_valid
);

  dll_pkg::ctrl_cmd_t           cmd;
  logic [dll_pkg::ID_W-1:0]     popped_id;
  logic [dll_pkg::COUNT_W-1:0]  item_count;
  logic                         is_empty;

  dll_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  dll_datapath #(.POOL_SIZE(POOL_SIZE)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (s_axis_tuser_i),
    .element_id_i   (s_axis_tdata_i),
    .popped_id_o    (popped_id),
    .popped_valid_o (m_axis_tuser_o),
    .item_count_o   (item_count),
    .is_empty_o     (is_empty)
  );

  assign m_axis_tdata_o = {6'b0, is_empty, item_count, popped_id};

endmodule

@@ src/dll_ram.sv @@
`timescale 1ns / 1ps

module dll_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dll_ctrl.sv @@
`timescale 1ns / 1ps

module dll_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output dll_pkg::ctrl_cmd_t   cmd_o
);

  dll_pkg::state_e state_q, state_d;
  logic            m_valid_q, m_valid_d;
  logic            out_free;

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dll_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = dll_pkg::ST_WR_A;
        end
      end
      dll_pkg::ST_WR_A: begin
        state_d = dll_pkg::ST_WR_B;
      end
      dll_pkg::ST_WR_B: begin
        state_d = out_free ? dll_pkg::ST_IDLE : dll_pkg::ST_HOLD;
      end
      dll_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = dll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dll_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    case (state_q)
      dll_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.accept    = s_axis_tvalid_i;
      end
      dll_pkg::ST_WR_A: begin
        cmd_o.step_a = 1'b1;
      end
      dll_pkg::ST_WR_B: begin
        cmd_o.step_b   = 1'b1;
        cmd_o.load_out = out_free;
      end
      dll_pkg::ST_HOLD: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dll_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

endmodule

@@ src/dll_datapath.sv @@
`timescale 1ns / 1ps

module dll_datapath #(
  parameter int POOL_SIZE = dll_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dll_pkg::ctrl_cmd_t           cmd_i,
  input  logic [dll_pkg::ACT_W-1:0]    action_i,
  input  logic [dll_pkg::ID_W-1:0]     element_id_i,
  output logic [dll_pkg::ID_W-1:0]     popped_id_o,
  output logic                         popped_valid_o,
  output logic [dll_pkg::COUNT_W-1:0]  item_count_o,
  output logic                         is_empty_o
);

  localparam int LINK_W = $clog2(POOL_SIZE + 1);
  localparam int ADDR_W = $clog2(POOL_SIZE);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

  function automatic logic in_pool(input logic [LINK_W-1:0] l);
    return l < NIL;
  endfunction

  // latched request
  dll_pkg::act_e     act_q;
  logic [LINK_W-1:0] elem_q;
  logic              elem_ok_q;

  // list registers
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] tail_q, tail_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;

  // second write slot, planned during slot A
  logic              bp_we_q, bp_we_d;
  logic [ADDR_W-1:0] bp_addr_q, bp_addr_d;
  logic [LINK_W-1:0] bp_data_q, bp_data_d;
  logic              bn_we_q, bn_we_d;
  logic [ADDR_W-1:0] bn_addr_q, bn_addr_d;
  logic [LINK_W-1:0] bn_data_q, bn_data_d;

  // first write slot
  logic              ap_we, an_we;
  logic [ADDR_W-1:0] ap_addr, an_addr;
  logic [LINK_W-1:0] ap_data, an_data;

  // result and output registers
  logic [LINK_W-1:0]          res_id_q, res_id_d;
  logic                       res_pv_q, res_pv_d;
  logic [dll_pkg::ID_W-1:0]    out_id_q;
  logic                       out_pv_q;
  logic [dll_pkg::COUNT_W-1:0] out_cnt_q;
  logic                       out_empty_q;

  // ram ports
  logic              prev_we, next_we;
  logic [ADDR_W-1:0] prev_waddr, next_waddr, prev_raddr, next_raddr;
  logic [LINK_W-1:0] prev_wdata, next_wdata, rd_p, rd_n;

  dll_pkg::act_e     act_in;
  logic [LINK_W-1:0] x;
  logic [LINK_W-1:0] x_prev;
  logic              empty;

  assign act_in = dll_pkg::act_e'(action_i);

  // pops read the neighbor of the end element, removes read both links of the element
  assign prev_raddr = (act_in == dll_pkg::ACT_POP_BACK) ? ADDR_W'(tail_q) :
                      ADDR_W'(element_id_i);
  assign next_raddr = (act_in == dll_pkg::ACT_POP_FRONT) ? ADDR_W'(head_q) :
                      ADDR_W'(element_id_i);

  dll_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (prev_raddr),
    .rdata_o (rd_p)
  );

  dll_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (next_raddr),
    .rdata_o (rd_n)
  );

  assign prev_we    = cmd_i.step_a ? ap_we : (cmd_i.step_b && bp_we_q);
  assign prev_waddr = cmd_i.step_a ? ap_addr : bp_addr_q;
  assign prev_wdata = cmd_i.step_a ? ap_data : bp_data_q;
  assign next_we    = cmd_i.step_a ? an_we : (cmd_i.step_b && bn_we_q);
  assign next_waddr = cmd_i.step_a ? an_addr : bn_addr_q;
  assign next_wdata = cmd_i.step_a ? an_data : bn_data_q;

  assign empty = (head_q == NIL);
  assign x     = (act_q == dll_pkg::ACT_POP_BACK) ? tail_q : head_q;
  // a null tail has no links of its own
  assign x_prev = in_pool(x) ? rd_p : NIL;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    ap_we     = 1'b0;
    ap_addr   = ADDR_W'(elem_q);
    ap_data   = NIL;
    an_we     = 1'b0;
    an_addr   = ADDR_W'(elem_q);
    an_data   = NIL;
    bp_we_d   = 1'b0;
    bp_addr_d = ADDR_W'(elem_q);
    bp_data_d = NIL;
    bn_we_d   = 1'b0;
    bn_addr_d = ADDR_W'(elem_q);
    bn_data_d = NIL;
    res_id_d  = '0;
    res_pv_d  = 1'b0;
    if (cmd_i.step_a) begin
      case (act_q)
        dll_pkg::ACT_PUSH_BACK, dll_pkg::ACT_PUSH_FRONT: begin
          if (elem_ok_q) begin
            if (cnt_q < NIL) begin
              cnt_d = cnt_q + LINK_W'(1);
            end
            ap_we = 1'b1;
            an_we = 1'b1;
            if (empty) begin
              head_d = elem_q;
              tail_d = elem_q;
            end else if (act_q == dll_pkg::ACT_PUSH_BACK) begin
              // own links first so a repeated push ends as written
              ap_data   = tail_q;
              bn_we_d   = in_pool(tail_q);
              bn_addr_d = ADDR_W'(tail_q);
              bn_data_d = elem_q;
              tail_d    = elem_q;
            end else begin
              an_data   = head_q;
              bp_we_d   = in_pool(head_q);
              bp_addr_d = ADDR_W'(head_q);
              bp_data_d = elem_q;
              head_d    = elem_q;
            end
          end
        end
        dll_pkg::ACT_POP_BACK, dll_pkg::ACT_POP_FRONT: begin
          if (!empty) begin
            if (cnt_q != '0) begin
              cnt_d = cnt_q - LINK_W'(1);
            end
            res_id_d = x;
            res_pv_d = 1'b1;
            if (head_q == tail_q) begin
              head_d  = NIL;
              tail_d  = NIL;
              ap_we   = 1'b1;
              ap_addr = ADDR_W'(x);
              an_we   = 1'b1;
              an_addr = ADDR_W'(x);
            end else if (act_q == dll_pkg::ACT_POP_BACK) begin
              tail_d    = x_prev;
              an_we     = in_pool(x_prev);
              an_addr   = ADDR_W'(x_prev);
              ap_we     = in_pool(x);
              ap_addr   = ADDR_W'(x);
              bn_we_d   = in_pool(x);
              bn_addr_d = ADDR_W'(x);
            end else begin
              head_d    = rd_n;
              ap_we     = in_pool(rd_n);
              ap_addr   = ADDR_W'(rd_n);
              an_we     = 1'b1;
              an_addr   = ADDR_W'(x);
              bp_we_d   = 1'b1;
              bp_addr_d = ADDR_W'(x);
            end
          end
        end
        dll_pkg::ACT_REMOVE: begin
          if (elem_ok_q) begin
            if (cnt_q != '0) begin
              cnt_d = cnt_q - LINK_W'(1);
            end
            if (rd_p == NIL && rd_n == NIL) begin
              // lone element: its own links stay as they are
              head_d = NIL;
              tail_d = NIL;
            end else begin
              // neighbors in slot A, the element itself in slot B
              bp_we_d = 1'b1;
              bn_we_d = 1'b1;
              if (rd_p == NIL) begin
                head_d  = rd_n;
                ap_we   = in_pool(rd_n);
                ap_addr = ADDR_W'(rd_n);
              end else if (rd_n == NIL) begin
                tail_d  = rd_p;
                an_we   = in_pool(rd_p);
                an_addr = ADDR_W'(rd_p);
              end else begin
                an_we   = in_pool(rd_p);
                an_addr = ADDR_W'(rd_p);
                an_data = rd_n;
                ap_we   = in_pool(rd_n);
                ap_addr = ADDR_W'(rd_n);
                ap_data = rd_p;
              end
            end
          end
        end
        default: begin
          res_pv_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NIL;
      tail_q  <= NIL;
      cnt_q   <= '0;
      bp_we_q <= 1'b0;
      bn_we_q <= 1'b0;
    end else if (cmd_i.step_a) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      bp_we_q <= bp_we_d;
      bn_we_q <= bn_we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q     <= act_in;
      elem_q    <= LINK_W'(element_id_i);
      elem_ok_q <= int'(element_id_i) < POOL_SIZE;
    end
    if (cmd_i.step_a) begin
      bp_addr_q <= bp_addr_d;
      bp_data_q <= bp_data_d;
      bn_addr_q <= bn_addr_d;
      bn_data_q <= bn_data_d;
      res_id_q  <= res_id_d;
      res_pv_q  <= res_pv_d;
    end
    if (cmd_i.load_out) begin
      out_id_q    <= dll_pkg::ID_W'(res_id_q);
      out_pv_q    <= res_pv_q;
      out_cnt_q   <= dll_pkg::COUNT_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
    end
  end

  assign popped_id_o    = out_id_q;
  assign popped_valid_o = out_pv_q;
  assign item_count_o   = out_cnt_q;
  assign is_empty_o     = out_empty_q;

endmodule

@@ src/dll_chk.sv @@
`timescale 1ns / 1ps

module dll_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [dll_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[17] == (m_axis_tdata_o[16:8] == 9'd0)))
    else $error("empty flag disagrees with count");

  a_no_pop_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("nonzero id without a pop");

endmodule

bind doubly_linked_list_manager_top dll_chk u_dll_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
